>>> hdl/scancode_key_fifo_unit_assert.svh
// Assertion macros for the scan-code key queue.
// Used by the top level only; no other dependencies.
`ifndef SCANCODE_KEY_FIFO_UNIT_ASSERT_SVH
`define SCANCODE_KEY_FIFO_UNIT_ASSERT_SVH
`ifndef SYNTH
`define SCKF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SCKF_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define SCKF_ASSERT(label, prop, msg)
`define SCKF_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

>>> hdl/sckf_pkg.sv
// Shared types, constants and the scan-code table for the key queue.
// No dependencies.
`default_nettype none
package sckf_pkg;

  localparam int unsigned QUEUE_DEPTH = 128;
  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    StPopped   = 3'd0,
    StEmpty    = 3'd1,
    StStored   = 3'd2,
    StUnmapped = 3'd3,
    StDropped  = 3'd4
  } status_e;

  localparam logic OpPush = 1'b0;
  localparam logic OpPop  = 1'b1;

  // result of one transaction, as held between the queue and the output register
  typedef struct packed {
    status_e    status;
    logic [6:0] char_val;
  } sckf_res_t;

  // make code to ASCII; zero means unmapped (break codes included)
  function automatic logic [6:0] map_code(input logic [7:0] code);
    logic [6:0] ch;
    unique case (code)
      8'h02:   ch = 7'h31;
      8'h03:   ch = 7'h32;
      8'h04:   ch = 7'h33;
      8'h05:   ch = 7'h34;
      8'h06:   ch = 7'h35;
      8'h07:   ch = 7'h36;
      8'h08:   ch = 7'h37;
      8'h09:   ch = 7'h38;
      8'h0A:   ch = 7'h39;
      8'h0B:   ch = 7'h30;
      8'h13:   ch = 7'h72;
      8'h32:   ch = 7'h6D;
      8'h1F:   ch = 7'h73;
      8'h1C:   ch = 7'h0A;
      8'h0E:   ch = 7'h08;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

>>> hdl/sckf_in_if.sv
// Channel interfaces for the key queue: request side and result side.
// Depends on nothing.
`default_nettype none
interface sckf_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] key_code;
  modport source (output valid, output operation, output key_code, input ready);
  modport sink (input valid, input operation, input key_code, output ready);
endinterface

interface sckf_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_out;
  logic [2:0] status;
  modport source (output valid, output char_out, output status, input ready);
  modport sink (input valid, input char_out, input status, output ready);
endinterface
`default_nettype wire

>>> hdl/sckf_queue.sv
// Character queue: table lookup, pointers, entry count and the store.
// Depends on sckf_pkg.
`default_nettype none
module sckf_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               acc_i,
  input  wire logic               operation_i,
  input  wire logic [7:0]         key_code_i,
  output sckf_pkg::sckf_res_t     res_o
);
  import sckf_pkg::*;

  logic [6:0]      mem_q [QUEUE_DEPTH];
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic [IdxW-1:0] wr_idx_q, wr_idx_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [6:0]      rdata_q;
  status_e         status_q, status_d;
  logic [6:0]      mapped;
  logic            do_push, do_pop;

  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] idx);
    return (idx == IdxW'(QUEUE_DEPTH - 1)) ? '0 : idx + IdxW'(1);
  endfunction

  always_comb begin
    mapped   = map_code(key_code_i);
    do_push  = 1'b0;
    do_pop   = 1'b0;
    status_d = status_q;
    if (operation_i == OpPop) begin
      if (cnt_q == '0) begin
        status_d = StEmpty;
      end else begin
        status_d = StPopped;
        do_pop   = acc_i;
      end
    end else begin
      if (mapped == '0) begin
        status_d = StUnmapped;
      end else if (cnt_q == CntW'(QUEUE_DEPTH)) begin
        status_d = StDropped;
      end else begin
        status_d = StStored;
        do_push  = acc_i;
      end
    end
    rd_idx_d = do_pop ? next_idx(rd_idx_q) : rd_idx_q;
    wr_idx_d = do_push ? next_idx(wr_idx_q) : wr_idx_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
      wr_idx_q <= '0;
      cnt_q    <= '0;
    end else begin
      rd_idx_q <= rd_idx_d;
      wr_idx_q <= wr_idx_d;
      cnt_q    <= cnt_d;
    end
  end

  // store and its registered read port
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_idx_q] <= mapped;
    end
    if (do_pop) begin
      rdata_q <= mem_q[rd_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      status_q <= status_d;
    end
  end

  assign res_o.status   = status_q;
  assign res_o.char_val = (status_q == StPopped) ? rdata_q : 7'h00;

endmodule
`default_nettype wire

>>> hdl/sckf_out_reg.sv
// Result register driving the output channel.
// Depends on sckf_pkg and sckf_out_if.
`default_nettype none
module sckf_out_reg (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s1_valid_i,
  input  wire sckf_pkg::sckf_res_t s1_res_i,
  output      logic                s1_take_o,
  sckf_out_if.source               out_o
);
  import sckf_pkg::*;

  logic      valid_q;
  sckf_res_t res_q;

  assign s1_take_o = s1_valid_i && (!valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s1_take_o) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take_o) begin
      res_q <= s1_res_i;
    end
  end

  assign out_o.valid    = valid_q;
  assign out_o.char_out = res_q.char_val;
  assign out_o.status   = res_q.status;

endmodule
`default_nettype wire

>>> hdl/scancode_key_fifo_unit.sv
// Scan-code key queue, top level: handshake and stage control.
// Depends on sckf_pkg, sckf_in_if/sckf_out_if, sckf_queue, sckf_out_reg
// and scancode_key_fifo_unit_assert.svh.
//
// Usage:
//  in_i carries one transaction per item: operation 0 pushes the character
//  mapped from key_code (15 make codes; anything else is ignored), operation 1
//  pops the oldest of up to 128 stored characters.
//  out_o returns exactly one transaction per item: char_out (zero unless a
//  character was popped) and status (popped, empty, stored, unmapped, dropped).
//  A taken request first updates the queue and its registered store read; the
//  result register then loads that result once it is free or out_o is ready.
//  Throughput: one item per cycle while out_o is not stalled; the store has one
//  write and one read port and each item uses at most one of them.
//  Reset clears the pointers and entry count; the store itself is not cleared
//  and needs no sweep, so requests are taken from the first cycle after reset.
//  When the receiver stalls, the result register holds and one more result
//  waits in the queue stage; in_i.ready then drops until out_o drains.
`default_nettype none
module scancode_key_fifo_unit (
  input wire logic clk_i,
  input wire logic rst_ni,
  sckf_in_if.sink  in_i,
  sckf_out_if.source out_o
);
  import sckf_pkg::*;
  `include "scancode_key_fifo_unit_assert.svh"

  logic      s1_valid_q;
  logic      s1_take;
  logic      acc;
  sckf_res_t s1_res;

  assign in_i.ready = !s1_valid_q || s1_take;
  assign acc        = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_take) begin
      s1_valid_q <= 1'b0;
    end
  end

  sckf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .operation_i (in_i.operation),
    .key_code_i  (in_i.key_code),
    .res_o       (s1_res)
  );

  sckf_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid_q),
    .s1_res_i   (s1_res),
    .s1_take_o  (s1_take),
    .out_o      (out_o)
  );

  `SCKF_ASSERT(a_pop_char_nonzero, (out_o.valid && out_o.status == StPopped) |-> (out_o.char_out != 7'h00), "popped character is zero")
  `SCKF_ASSERT(a_other_char_zero, (out_o.valid && out_o.status != StPopped) |-> (out_o.char_out == 7'h00), "character on non-pop result")
  `SCKF_ASSERT(a_stall_blocks_in, (s1_valid_q && out_o.valid && !out_o.ready) |-> !in_i.ready, "request taken while both stages stalled")
  `SCKF_ASSERT_NEXT(a_accept_fills, acc, s1_valid_q, "accepted request not held in queue stage")

endmodule
`default_nettype wire
